/* rtl/xxhash64_stream_hasher_top_assert.svh */
// ----------------------------------------------------------------------------
// xxHash64 stream hasher assertion macros
// Immediate-consequence and next-cycle checks, clocked on clk, reset rst_n.
// ----------------------------------------------------------------------------
`ifndef XXHASH64_STREAM_HASHER_TOP_ASSERT_SVH
`define XXHASH64_STREAM_HASHER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define XXH_AST_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("xxh assertion failed");
`define XXH_AST_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("xxh assertion failed");
`else
`define XXH_AST_IMP(lbl, ante, cons)
`define XXH_AST_NXT(lbl, ante, cons)
`endif

`endif

/* rtl/xxh_pkg.sv */
// ----------------------------------------------------------------------------
// xxh_pkg
// Shared types, primes and helpers of the xxHash64 stream hasher.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package xxh_pkg;

  localparam logic [63:0] PR1 = 64'h9e3779b185ebca87;
  localparam logic [63:0] PR2 = 64'hc2b2ae3d27d4eb4f;
  localparam logic [63:0] PR3 = 64'h165667b19e3779f9;
  localparam logic [63:0] PR4 = 64'h85ebca77c2b2ae63;
  localparam logic [63:0] PR5 = 64'h27d4eb2f165667c5;

  localparam logic [3:0] WORD_BYTES = 4'd8;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned r);
    return (x << r) | (x >> (64 - r));
  endfunction

endpackage

/* rtl/xxh_front.sv */
// ----------------------------------------------------------------------------
// xxh_front
// Accepts input words, normalizes the byte count and queues them (two deep).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xxhash64_stream_hasher_top_assert.svh"

module xxh_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [63:0]   in_data_word,
  input  logic [3:0]    in_bytes_valid,
  input  logic          in_last,
  output logic          q_valid,
  output xxh_pkg::item_t q_item,
  input  logic          q_pop
);

  xxh_pkg::item_t q_mem_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push;
  xxh_pkg::item_t cls;

  // Classify: a non-final word always counts as a full word.
  always_comb begin
    cls.word   = in_data_word;
    cls.last   = in_last;
    cls.nbytes = xxh_pkg::WORD_BYTES;
    if (in_last && in_bytes_valid < xxh_pkg::WORD_BYTES) begin
      cls.nbytes = in_bytes_valid;
    end
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = q_mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  `XXH_AST_IMP(a_q_full_word, q_valid && !q_item.last, q_item.nbytes == xxh_pkg::WORD_BYTES)
  `XXH_AST_IMP(a_pop_has_data, q_pop, q_valid)

endmodule

/* rtl/xxh_mul.sv */
// ----------------------------------------------------------------------------
// xxh_mul
// Low 64 bits of a 64x64 product from three 32x32 partial products.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xxh_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  xxh_pkg::mul_req_t req,
  output logic              done,
  output logic [63:0]       res
);

  logic [63:0] a_r;
  logic [63:0] b_r;
  logic [63:0] p_r;
  logic [1:0]  cnt_r;
  logic        done_r;
  logic [31:0] opx;
  logic [31:0] opy;
  logic [63:0] prod;

  // Pick the partial product for this step.
  always_comb begin
    opx = a_r[31:0];
    opy = b_r[31:0];
    unique case (cnt_r)
      2'd2:    opx = a_r[63:32];
      2'd3:    opy = b_r[63:32];
      default: ;
    endcase
  end

  assign prod = {32'd0, opx} * {32'd0, opy};
  assign done = done_r;
  assign res  = p_r;

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (cnt_r == 2'd1) begin
      p_r <= prod;
    end else if (cnt_r != 2'd0) begin
      p_r[63:32] <= p_r[63:32] + prod[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == 2'd3);
      if (req.start) begin
        cnt_r <= 2'd1;
      end else if (cnt_r != 2'd0) begin
        cnt_r <= cnt_r + 2'd1;
      end
    end
  end

endmodule

/* rtl/xxh_core.sv */
// ----------------------------------------------------------------------------
// xxh_core
// Sequencer that absorbs stripes, finalizes and emits the hash.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "xxhash64_stream_hasher_top_assert.svh"

module xxh_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [63:0]    seed,
  input  logic           q_valid,
  input  xxh_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [63:0]    out_hash
);

  typedef enum logic [4:0] {
    S_IDLE, S_ABS_M1, S_ABS_M2, S_FIN, S_MRG_M1, S_MRG_M2, S_MRG_M3, S_LEN,
    S_LEFT_M1, S_LEFT_M2, S_LEFT_M3, S_TAIL, S_C4_M1, S_C4_M2, S_B_M1, S_B_M2,
    S_AV1, S_AV2, S_OUT
  } state_t;

  state_t            state_r;
  logic [63:0]       lane_r [4];
  logic [63:0]       buf_r [4];
  logic [1:0]        fill_r;
  logic [1:0]        idx_r;
  logic              seen_r;
  logic              new_msg_r;
  logic              last_r;
  logic [63:0]       total_r;
  logic [63:0]       tail_r;
  logic [3:0]        n_r;
  logic [63:0]       h_r;
  logic [63:0]       t_r;
  logic              mul_pend_r;
  logic              out_valid_r;
  logic [63:0]       hash_r;

  xxh_pkg::mul_req_t mreq;
  logic              mul_done;
  logic [63:0]       mul_res;
  logic              is_mul;
  logic [1:0]        fill_eff;
  logic [63:0]       tail_mask;
  logic              full;
  logic              out_load;

  xxh_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mreq),
    .done (mul_done),
    .res  (mul_res)
  );

  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign fill_eff  = new_msg_r ? 2'd0 : fill_r;
  assign full      = (q_item.nbytes == xxh_pkg::WORD_BYTES);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_hash  = hash_r;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      tail_mask[k*8 +: 8] = (4'(k) < q_item.nbytes) ? 8'hff : 8'h00;
    end
  end

  // Multiplier operands for each step.
  always_comb begin
    is_mul = 1'b1;
    mreq.a = h_r;
    mreq.b = xxh_pkg::PR1;
    unique case (state_r)
      S_ABS_M1:  begin mreq.a = buf_r[idx_r];  mreq.b = xxh_pkg::PR2; end
      S_ABS_M2:  mreq.a = t_r;
      S_MRG_M1:  begin mreq.a = lane_r[idx_r]; mreq.b = xxh_pkg::PR2; end
      S_MRG_M2:  mreq.a = t_r;
      S_MRG_M3:  mreq.a = h_r;
      S_LEFT_M1: begin mreq.a = buf_r[idx_r];  mreq.b = xxh_pkg::PR2; end
      S_LEFT_M2: mreq.a = t_r;
      S_LEFT_M3: mreq.a = xxh_pkg::rotl64(h_r, 27);
      S_C4_M1:   mreq.a = {32'd0, tail_r[31:0]};
      S_C4_M2:   begin mreq.a = xxh_pkg::rotl64(h_r, 23); mreq.b = xxh_pkg::PR2; end
      S_B_M1:    begin mreq.a = {56'd0, tail_r[7:0]}; mreq.b = xxh_pkg::PR5; end
      S_B_M2:    mreq.a = xxh_pkg::rotl64(h_r, 11);
      S_AV1:     begin mreq.a = h_r ^ (h_r >> 33); mreq.b = xxh_pkg::PR2; end
      S_AV2:     begin mreq.a = h_r ^ (h_r >> 29); mreq.b = xxh_pkg::PR3; end
      default:   is_mul = 1'b0;
    endcase
    mreq.start = is_mul && !mul_pend_r;
  end

  // Data registers without reset.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && q_valid) begin
      if (new_msg_r) begin
        lane_r[0] <= seed + xxh_pkg::PR1 + xxh_pkg::PR2;
        lane_r[1] <= seed + xxh_pkg::PR2;
        lane_r[2] <= seed;
        lane_r[3] <= seed - xxh_pkg::PR1;
      end
      if (full) begin
        buf_r[fill_eff] <= q_item.word;
      end
    end
    if (state_r == S_ABS_M2 && mul_done) begin
      lane_r[idx_r] <= mul_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      new_msg_r   <= 1'b1;
      fill_r      <= 2'd0;
      idx_r       <= 2'd0;
      seen_r      <= 1'b0;
      last_r      <= 1'b0;
      n_r         <= 4'd0;
      total_r     <= 64'd0;
      mul_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (mreq.start) begin
        mul_pend_r <= 1'b1;
      end else if (mul_done) begin
        mul_pend_r <= 1'b0;
      end
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            n_r    <= full ? 4'd0 : q_item.nbytes;
            tail_r <= q_item.word & tail_mask;
            last_r <= q_item.last;
            if (new_msg_r) begin
              seen_r    <= 1'b0;
              new_msg_r <= 1'b0;
              total_r   <= {60'd0, q_item.nbytes};
            end else begin
              total_r   <= total_r + {60'd0, q_item.nbytes};
            end
            if (full && fill_eff == 2'd3) begin
              idx_r   <= 2'd0;
              state_r <= S_ABS_M1;
            end else if (full) begin
              fill_r  <= fill_eff + 2'd1;
              state_r <= q_item.last ? S_FIN : S_IDLE;
            end else begin
              fill_r  <= fill_eff;
              state_r <= S_FIN;
            end
          end
        end
        S_ABS_M1: begin
          if (mul_done) begin
            t_r     <= xxh_pkg::rotl64(lane_r[idx_r] + mul_res, 31);
            state_r <= S_ABS_M2;
          end
        end
        S_ABS_M2: begin
          if (mul_done) begin
            if (idx_r == 2'd3) begin
              fill_r  <= 2'd0;
              seen_r  <= 1'b1;
              state_r <= last_r ? S_FIN : S_IDLE;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_ABS_M1;
            end
          end
        end
        S_FIN: begin
          idx_r <= 2'd0;
          if (seen_r) begin
            h_r <= xxh_pkg::rotl64(lane_r[0], 1) + xxh_pkg::rotl64(lane_r[1], 7)
                 + xxh_pkg::rotl64(lane_r[2], 12) + xxh_pkg::rotl64(lane_r[3], 18);
            state_r <= S_MRG_M1;
          end else begin
            h_r     <= seed + xxh_pkg::PR5;
            state_r <= S_LEN;
          end
        end
        S_MRG_M1: begin
          if (mul_done) begin
            t_r     <= xxh_pkg::rotl64(mul_res, 31);
            state_r <= S_MRG_M2;
          end
        end
        S_MRG_M2: begin
          if (mul_done) begin
            h_r     <= h_r ^ mul_res;
            state_r <= S_MRG_M3;
          end
        end
        S_MRG_M3: begin
          if (mul_done) begin
            h_r <= mul_res + xxh_pkg::PR4;
            if (idx_r == 2'd3) begin
              state_r <= S_LEN;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_MRG_M1;
            end
          end
        end
        S_LEN: begin
          h_r     <= h_r + total_r;
          idx_r   <= 2'd0;
          state_r <= (fill_r == 2'd0) ? S_TAIL : S_LEFT_M1;
        end
        S_LEFT_M1: begin
          if (mul_done) begin
            t_r     <= xxh_pkg::rotl64(mul_res, 31);
            state_r <= S_LEFT_M2;
          end
        end
        S_LEFT_M2: begin
          if (mul_done) begin
            h_r     <= h_r ^ mul_res;
            state_r <= S_LEFT_M3;
          end
        end
        S_LEFT_M3: begin
          if (mul_done) begin
            h_r <= mul_res + xxh_pkg::PR4;
            if (idx_r + 2'd1 == fill_r) begin
              state_r <= S_TAIL;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= S_LEFT_M1;
            end
          end
        end
        S_TAIL: begin
          priority if (n_r >= 4'd4) begin
            state_r <= S_C4_M1;
          end else if (n_r != 4'd0) begin
            state_r <= S_B_M1;
          end else begin
            state_r <= S_AV1;
          end
        end
        S_C4_M1: begin
          if (mul_done) begin
            h_r     <= h_r ^ mul_res;
            state_r <= S_C4_M2;
          end
        end
        S_C4_M2: begin
          if (mul_done) begin
            h_r     <= mul_res + xxh_pkg::PR3;
            tail_r  <= tail_r >> 32;
            n_r     <= n_r - 4'd4;
            state_r <= S_TAIL;
          end
        end
        S_B_M1: begin
          if (mul_done) begin
            h_r     <= h_r ^ mul_res;
            state_r <= S_B_M2;
          end
        end
        S_B_M2: begin
          if (mul_done) begin
            h_r     <= mul_res;
            tail_r  <= tail_r >> 8;
            n_r     <= n_r - 4'd1;
            state_r <= S_TAIL;
          end
        end
        S_AV1: begin
          if (mul_done) begin
            h_r     <= mul_res;
            state_r <= S_AV2;
          end
        end
        S_AV2: begin
          if (mul_done) begin
            h_r     <= mul_res;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            hash_r      <= h_r ^ (h_r >> 32);
            out_valid_r <= 1'b1;
            new_msg_r   <= 1'b1;
            fill_r      <= 2'd0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `XXH_AST_IMP(a_done_pending, mul_done, mul_pend_r)
  `XXH_AST_IMP(a_pop_quiet_mul, q_pop, !mul_pend_r)
  `XXH_AST_NXT(a_out_load, out_load, out_valid_r && new_msg_r && state_r == S_IDLE)

endmodule

/* rtl/xxhash64_stream_hasher_top.sv */
// ----------------------------------------------------------------------------
// xxhash64_stream_hasher_top
// Streaming XXH64 engine: word queue in front, multiply sequencer behind.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per little-endian
//   8-byte message word. in_last marks the final word; on it in_bytes_valid
//   (0..8, larger values count as 8) gives the valid low-order bytes.
//   Result channel (out_valid / out_stall): one transaction per message,
//   carrying out_hash. Config: pulse cfg_we with cfg_wdata to set the seed,
//   only while no message is in flight.
// Arithmetic:
//   All multiplies run on one shared 64-bit multiplier built from three
//   32x32 partial products. A word that does not complete a stripe is only
//   buffered; a stripe costs 8 multiplies. Finalization takes 12 multiplies
//   when a stripe was absorbed, plus 3 per leftover word, 2 for a 4-byte
//   chunk, 2 per single byte and 2 for the avalanche.
//   A two-entry queue accepts up to two words while the engine works.
// Reset: synchronous, active low; seed returns to zero, the queue empties,
//   and the next word starts a new message.
// Stall: a held result keeps its value; the engine keeps absorbing words
//   of the next message and waits only when another hash is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xxhash64_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_word,
  input  logic [3:0]  in_bytes_valid,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_hash
);

  logic [63:0]    seed_r;
  logic           q_valid;
  logic           q_pop;
  xxh_pkg::item_t q_item;

  // Hold the seed; lanes pick it up at the first word of each message.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 64'd0;
    end else if (cfg_we) begin
      seed_r <= cfg_wdata;
    end
  end

  // Front: accept and normalize words into the queue.
  xxh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data_word  (in_data_word),
    .in_bytes_valid(in_bytes_valid),
    .in_last       (in_last),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  // Back: absorb stripes, finalize, drive the result register.
  xxh_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .seed     (seed_r),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hash (out_hash)
  );

endmodule

/* test/xxhash64_stream_hasher_top_test.sv */
// ----------------------------------------------------------------------------
// xxHash64 stream hasher testbench
// Streams messages word by word through the hasher, predicts each XXH64
// digest in a behavioral model and compares it with the result channel,
// under random idling on both sides, a long result hold-off and seed changes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module xxhash64_stream_hasher_top_test;

  localparam int HALF_NS = 6;
  // Worst finalization is 31 multiplies; the drain wait allows ample margin.
  localparam int DRAIN_CYCLES = 400;

  typedef struct {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        check_hash;
    logic [63:0] hash;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] in_data_word = '0;
  logic [3:0]  in_bytes_valid = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_hash;

  // Predictor state, one copy of what the hasher keeps.
  logic [63:0] seed_reg;
  logic [63:0] lane_acc [4];
  logic [63:0] stripe_words [4];
  int unsigned fill_cnt;
  logic [63:0] msg_len;
  bit          stripe_done;
  bit          msg_idle;

  logic [63:0] hash_queue [$];
  bit          hash_known [$];
  logic [63:0] hash_fixed [$];
  int          mismatch_cnt = 0;
  int          hash_cnt = 0;
  int          word_cnt = 0;
  int          idle_pct = 22;
  int          hold_cycles = 0;
  bit          hold_fired = 1'b0;
  bit          sending_done = 1'b0;

  xxhash64_stream_hasher_top i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_data_word(in_data_word),
    .in_bytes_valid(in_bytes_valid), .in_last(in_last),
    .out_valid(out_valid), .out_stall(out_stall), .out_hash(out_hash)
  );

  always #HALF_NS clk = ~clk;

  function automatic logic [63:0] rot_left(logic [63:0] x, int r);
    return (r == 0) ? x : ((x << r) | (x >> (64 - r)));
  endfunction

  function automatic logic [63:0] round_lane(logic [63:0] acc, logic [63:0] w);
    acc = acc + w * xxh_pkg::PR2;
    return rot_left(acc, 31) * xxh_pkg::PR1;
  endfunction

  function automatic void load_lanes();
    lane_acc[0] = seed_reg + xxh_pkg::PR1 + xxh_pkg::PR2;
    lane_acc[1] = seed_reg + xxh_pkg::PR2;
    lane_acc[2] = seed_reg;
    lane_acc[3] = seed_reg - xxh_pkg::PR1;
  endfunction

  function automatic void buffer_word(logic [63:0] w);
    stripe_words[fill_cnt] = w;
    fill_cnt++;
    if (fill_cnt == 4) begin
      for (int i = 0; i < 4; i++) lane_acc[i] = round_lane(lane_acc[i], stripe_words[i]);
      fill_cnt = 0;
      stripe_done = 1'b1;
    end
  endfunction

  // Absorb one accepted word; return 1 with the digest when it ends a message.
  function automatic bit hash_word(logic [63:0] w, logic [3:0] nb, logic fin,
                                   output logic [63:0] h);
    int unsigned n;
    logic [63:0] tail;
    h = '0;
    if (msg_idle) begin
      load_lanes();
      fill_cnt = 0;
      msg_len = '0;
      stripe_done = 1'b0;
      msg_idle = 1'b0;
    end
    if (!fin) begin
      msg_len += 64'd8;
      buffer_word(w);
      return 1'b0;
    end
    n = (nb > 8) ? 8 : nb;
    msg_len += 64'(n);
    tail = '0;
    if (n == 8) begin
      buffer_word(w);
      n = 0;
    end else begin
      tail = w & ((64'd1 << (n * 8)) - 64'd1);
    end
    if (stripe_done) begin
      h = rot_left(lane_acc[0], 1) + rot_left(lane_acc[1], 7) +
          rot_left(lane_acc[2], 12) + rot_left(lane_acc[3], 18);
      for (int i = 0; i < 4; i++)
        h = ((h ^ round_lane(64'd0, lane_acc[i])) * xxh_pkg::PR1) + xxh_pkg::PR4;
    end else begin
      h = seed_reg + xxh_pkg::PR5;
    end
    h += msg_len;
    for (int i = 0; i < fill_cnt; i++) begin
      h ^= round_lane(64'd0, stripe_words[i]);
      h = rot_left(h, 27) * xxh_pkg::PR1 + xxh_pkg::PR4;
    end
    if (n >= 4) begin
      h ^= (tail & 64'hffff_ffff) * xxh_pkg::PR1;
      h = rot_left(h, 23) * xxh_pkg::PR2 + xxh_pkg::PR3;
      tail >>= 32;
      n -= 4;
    end
    while (n > 0) begin
      h ^= (tail & 64'hff) * xxh_pkg::PR5;
      h = rot_left(h, 11) * xxh_pkg::PR1;
      tail >>= 8;
      n--;
    end
    h ^= h >> 33;
    h *= xxh_pkg::PR2;
    h ^= h >> 29;
    h *= xxh_pkg::PR3;
    h ^= h >> 32;
    msg_idle = 1'b1;
    fill_cnt = 0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  // Offer one word and hold it until accepted; then record the prediction.
  // Valid stays up until the next word or an explicit drop by the caller.
  task automatic send_word(logic [63:0] w, logic [3:0] nb, logic fin,
                           bit known, logic [63:0] fixed_hash);
    logic [63:0] h;
    while (($urandom_range(99) < idle_pct) && (hold_cycles == 0)) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_word <= w;
    in_bytes_valid <= nb;
    in_last <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    word_cnt++;
    if (hash_word(w, nb, fin, h)) begin
      hash_queue.push_back(h);
      hash_known.push_back(known);
      hash_fixed.push_back(fixed_hash);
    end
    @(negedge clk);
  endtask

  // Change the seed with the hasher idle: drain results, then let it settle.
  task automatic write_seed(logic [63:0] value);
    in_valid <= 1'b0;
    while (hash_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    seed_reg = value;
  endtask

  // Random message; mostly short, sometimes several stripes long.
  task automatic send_message(int nwords);
    for (int i = 0; i < nwords; i++) begin
      logic [63:0] w;
      logic [3:0]  nb;
      w = {$urandom, $urandom};
      if ($urandom_range(9) == 0) w = ($urandom_range(1) != 0) ? '1 : '0;
      nb = (i == nwords - 1) ? 4'($urandom_range(15)) : 4'($urandom_range(15));
      if (i == nwords - 1 && $urandom_range(3) != 0) nb = 4'($urandom_range(8));
      send_word(w, nb, i == nwords - 1, 1'b0, '0);
    end
  endtask

  // Result side: random stalls, then compare with the oldest prediction.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (hash_queue.size() == 0) begin
        report_mismatch("unexpected hash", out_hash, '0);
      end else begin
        if (out_hash !== hash_queue[0]) report_mismatch("hash", out_hash, hash_queue[0]);
        if (hash_known[0] && out_hash !== hash_fixed[0])
          report_mismatch("known hash", out_hash, hash_fixed[0]);
        void'(hash_queue.pop_front());
        void'(hash_known.pop_front());
        void'(hash_fixed.pop_front());
        hash_cnt++;
      end
    end
  end

  // Directed stimulus; known digests are the published XXH64 values.
  dir_row_t dir_rows [] = '{
    '{64'h0, 4'd0, 1'b1, 1'b1, 64'hef46db3751d8e999},
    '{64'h61, 4'd1, 1'b1, 1'b1, 64'hd24ec4f1a98c6e5b},
    '{64'hffff_ffff_ffff_ff61, 4'd1, 1'b1, 1'b1, 64'hd24ec4f1a98c6e5b},
    '{64'h6463_6261, 4'd4, 1'b1, 1'b0, '0},
    '{64'hffff_ffff_ffff_ffff, 4'd8, 1'b1, 1'b0, '0},
    '{64'hffff_ffff_ffff_ffff, 4'd15, 1'b1, 1'b0, '0},
    '{64'h0, 4'd9, 1'b1, 1'b0, '0},
    '{64'h0123_4567_89ab_cdef, 4'd3, 1'b0, 1'b0, '0},
    '{64'hffff_ffff_ffff_ffff, 4'd7, 1'b1, 1'b0, '0},
    '{64'h1, 4'd0, 1'b0, 1'b0, '0},
    '{64'h2, 4'd0, 1'b0, 1'b0, '0},
    '{64'h3, 4'd0, 1'b0, 1'b0, '0},
    '{64'h4, 4'd8, 1'b1, 1'b0, '0},
    '{64'hffff_ffff_ffff_ffff, 4'd8, 1'b0, 1'b0, '0},
    '{64'h0, 4'd8, 1'b0, 1'b0, '0},
    '{64'haaaa_aaaa_aaaa_aaaa, 4'd8, 1'b0, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 4'd8, 1'b0, 1'b0, '0},
    '{64'hdead_beef_cafe_f00d, 4'd6, 1'b1, 1'b0, '0}
  };

  initial begin
    logic [63:0] seed_list [4];
    seed_reg = '0;
    msg_idle = 1'b1;
    fill_cnt = 0;
    msg_len = '0;
    stripe_done = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Reset seed is zero; walk the directed table.
    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].nbytes, dir_rows[i].last,
                dir_rows[i].check_hash, dir_rows[i].hash);
    // Seed change between messages, then another in the middle of a message: lanes keep the old seed.
    write_seed(64'h0000_0000_0000_0001);
    for (int i = 0; i < 5; i++) send_word({$urandom, $urandom}, 4'd8, 1'b0, 1'b0, '0);
    // Let the accepted words settle before touching the seed.
    in_valid <= 1'b0;
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 64'hffff_ffff_ffff_ffff;
    @(negedge clk);
    cfg_we <= 1'b0;
    seed_reg = 64'hffff_ffff_ffff_ffff;
    send_word({$urandom, $urandom}, 4'd5, 1'b1, 1'b0, '0);

    seed_list = '{64'h0, 64'hffff_ffff_ffff_ffff, 64'h0, 64'h0};
    seed_list[2] = {$urandom, $urandom};
    seed_list[3] = {$urandom, $urandom};
    for (int phase = 0; phase < 4; phase++) begin
      write_seed(seed_list[phase]);
      if (phase == 1) idle_pct = 0;     // stretch with no idling at all
      else idle_pct = 22;
      while (word_cnt < 60 + (phase + 1) * 470) begin
        if (phase == 2 && word_cnt > 1100 && !hold_fired) begin
          hold_cycles = 600;
          hold_fired = 1'b1;
        end
        send_message(($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6));
      end
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  initial begin
    wait (sending_done);
    while (hash_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d words and %0d digests over several seeds", word_cnt, hash_cnt);
    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/xxh_pkg.sv
rtl/xxh_front.sv
rtl/xxh_mul.sv
rtl/xxh_core.sv
rtl/xxhash64_stream_hasher_top.sv
test/xxhash64_stream_hasher_top_test.sv
